>>> sv/gsa_pkg.sv
package gsa_pkg;

    // defaults for the top-level parameters
    localparam int DEF_SLOT_COUNT   = 1024;
    localparam int DEF_VERSION_BITS = 16;

    // fixed field widths of the request and result ports
    localparam int SLOT_W    = 10;
    localparam int INDEX_W   = 10;
    localparam int VERSION_W = 16;
    localparam int STATUS_W  = 2;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

endpackage

>>> sv/gsa_store.sv
module gsa_store #(
    parameter int SLOT_COUNT   = gsa_pkg::DEF_SLOT_COUNT,
    parameter int VERSION_BITS = gsa_pkg::DEF_VERSION_BITS,
    localparam int IDX_W  = $clog2(SLOT_COUNT),
    localparam int HEAD_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [IDX_W-1:0]        i_rd_addr,
    output logic [HEAD_W-1:0]       o_rd_link,
    output logic [VERSION_BITS-1:0] o_rd_ver,
    input  logic [IDX_W-1:0]        i_wr_addr,
    input  logic                    i_wr_link_en,
    input  logic [HEAD_W-1:0]       i_wr_link,
    input  logic                    i_wr_ver_en,
    input  logic [VERSION_BITS-1:0] i_wr_ver
);

    // link and version stores, one entry per slot, registered read
    logic [HEAD_W-1:0]       r_link_mem [SLOT_COUNT];
    logic [VERSION_BITS-1:0] r_ver_mem  [SLOT_COUNT];
    logic [HEAD_W-1:0]       r_rd_link;
    logic [VERSION_BITS-1:0] r_rd_ver;

    always_ff @(posedge i_clk) begin
        if (i_wr_link_en) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_rd_en) begin
            r_rd_link <= r_link_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_ver_en) begin
            r_ver_mem[i_wr_addr] <= i_wr_ver;
        end
        if (i_rd_en) begin
            r_rd_ver <= r_ver_mem[i_rd_addr];
        end
    end

    assign o_rd_link = r_rd_link;
    assign o_rd_ver  = r_rd_ver;

endmodule

>>> sv/generational_slot_allocator.sv
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+-------------------------------------
// request  | in        | i_in_valid / o_in_ready    | i_operation, i_slot
// result   | out       | o_out_valid / i_out_ready  | o_status, o_handle_index,
//          |           |                            | o_handle_version
//
// one request passes two states: the accept in S_IDLE issues the read of the link and
// version stores, and S_EXEC reads, modifies and writes them back
// the registered read of the link store forces this split: an allocate only knows
// the next free-list head once the link of the old head has come out of memory
// synchronous active-low reset empties the free list and clears the high-water mark;
// the stores need no clearing, no entry's contents are used before it has been written
// a result waiting in the output register does not block the next accept; the
// write-back stage holds until the output register is free
module generational_slot_allocator #(
    parameter int SLOT_COUNT   = gsa_pkg::DEF_SLOT_COUNT,
    parameter int VERSION_BITS = gsa_pkg::DEF_VERSION_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_operation,
    input  logic [gsa_pkg::SLOT_W-1:0]     i_slot,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gsa_pkg::STATUS_W-1:0]   o_status,
    output logic [gsa_pkg::INDEX_W-1:0]    o_handle_index,
    output logic [gsa_pkg::VERSION_W-1:0]  o_handle_version
);

    localparam int IDX_W  = $clog2(SLOT_COUNT);
    localparam int HEAD_W = $clog2(SLOT_COUNT + 1);
    localparam logic [HEAD_W-1:0] EMPTY = HEAD_W'(SLOT_COUNT);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    // free-list head (EMPTY means no free slot) and high-water mark
    logic [HEAD_W-1:0] r_head, n_head;
    logic [HEAD_W-1:0] r_used, n_used;

    // captured request
    logic                       r_op;
    logic [gsa_pkg::SLOT_W-1:0] r_slot;

    // output register
    logic                          r_out_valid, n_out_valid;
    gsa_pkg::t_status              r_status, n_status;
    logic [gsa_pkg::INDEX_W-1:0]   r_index, n_index;
    logic [gsa_pkg::VERSION_W-1:0] r_version, n_version;

    // store interface
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [HEAD_W-1:0]       rd_link;
    logic [VERSION_BITS-1:0] rd_ver;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_link_en;
    logic [HEAD_W-1:0]       wr_link;
    logic                    wr_ver_en;
    logic [VERSION_BITS-1:0] wr_ver;

    logic in_accept;
    logic out_free;
    logic head_empty;
    logic slot_bad;
    logic [VERSION_BITS-1:0] bumped;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // the read goes out at accept: old head for an allocate, given slot for a free
    assign rd_en   = in_accept;
    assign rd_addr = (i_operation == gsa_pkg::OP_FREE) ? IDX_W'(i_slot) : r_head[IDX_W-1:0];

    assign head_empty = (r_head >= EMPTY);
    // anything at or above the high-water mark was never handed out
    assign slot_bad   = (32'(r_slot) >= 32'(r_used));
    assign bumped     = rd_ver + VERSION_BITS'(1);

    gsa_store #(
        .SLOT_COUNT   (SLOT_COUNT),
        .VERSION_BITS (VERSION_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_link    (rd_link),
        .o_rd_ver     (rd_ver),
        .i_wr_addr    (wr_addr),
        .i_wr_link_en (wr_link_en),
        .i_wr_link    (wr_link),
        .i_wr_ver_en  (wr_ver_en),
        .i_wr_ver     (wr_ver)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_used      = r_used;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_index     = r_index;
        n_version   = r_version;
        wr_addr     = r_used[IDX_W-1:0];
        wr_link_en  = 1'b0;
        wr_link     = r_head;
        wr_ver_en   = 1'b0;
        wr_ver      = bumped;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = gsa_pkg::ST_OK;
                    n_index     = '0;
                    n_version   = '0;
                    if (r_op == gsa_pkg::OP_ALLOC) begin
                        priority if (!head_empty) begin
                            // pop the head; its link becomes the new head
                            n_index   = gsa_pkg::INDEX_W'(r_head[IDX_W-1:0]);
                            n_version = gsa_pkg::VERSION_W'(rd_ver);
                            n_head    = rd_link;
                        end else if (r_used < EMPTY) begin
                            // fresh slot at version zero
                            n_index   = gsa_pkg::INDEX_W'(r_used[IDX_W-1:0]);
                            wr_addr   = r_used[IDX_W-1:0];
                            wr_ver_en = 1'b1;
                            wr_ver    = '0;
                            n_used    = r_used + HEAD_W'(1);
                        end else begin
                            n_status = gsa_pkg::ST_FULL;
                        end
                    end else begin
                        n_index = gsa_pkg::INDEX_W'(r_slot);
                        if (slot_bad) begin
                            n_status = gsa_pkg::ST_INVALID;
                        end else begin
                            // push onto the list and bump the version
                            wr_addr    = IDX_W'(r_slot);
                            wr_link_en = 1'b1;
                            wr_link    = r_head;
                            wr_ver_en  = 1'b1;
                            wr_ver     = bumped;
                            n_version  = gsa_pkg::VERSION_W'(bumped);
                            n_head     = HEAD_W'(r_slot);
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= EMPTY;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= i_operation;
            r_slot <= i_slot;
        end
        r_status  <= n_status;
        r_index   <= n_index;
        r_version <= n_version;
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_handle_index   = r_index;
    assign o_handle_version = r_version;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= EMPTY)
        else $error("high-water mark beyond slot count");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == EMPTY) || (r_head < r_used))
        else $error("free-list head points at a slot never handed out");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_link_en || wr_ver_en) |-> (r_state == S_EXEC) && out_free)
        else $error("store written outside write-back");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted request did not reach write-back");

    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EXEC) && out_free) |=> r_out_valid && (r_state == S_IDLE))
        else $error("write-back did not produce a result");

endmodule

>>> bench/tb_generational_slot_allocator.sv
`timescale 1ns / 1ps

module tb_generational_slot_allocator;

    localparam int SLOTS       = gsa_pkg::DEF_SLOT_COUNT;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        gsa_pkg::t_op                 op;
        logic [gsa_pkg::SLOT_W-1:0]   slot;
    } t_request;

    typedef struct {
        gsa_pkg::t_status              status;
        logic [gsa_pkg::INDEX_W-1:0]   idx;
        logic [gsa_pkg::VERSION_W-1:0] version;
    } t_handle;

    // dut ports, inputs known from time zero
    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_in_valid       = 1'b0;
    logic                          o_in_ready;
    logic                          i_operation      = 1'b0;
    logic [gsa_pkg::SLOT_W-1:0]    i_slot           = '0;
    logic                          o_out_valid;
    logic                          i_out_ready      = 1'b0;
    logic [gsa_pkg::STATUS_W-1:0]  o_status;
    logic [gsa_pkg::INDEX_W-1:0]   o_handle_index;
    logic [gsa_pkg::VERSION_W-1:0] o_handle_version;

    // requests waiting for the driver, handles waiting for the dut
    t_request request_queue[$];
    t_handle  expected_handles[$];

    // allocator shadow state, updated in request order at accept time
    logic [10:0]                   link_mem[SLOTS];
    logic [gsa_pkg::VERSION_W-1:0] version_mem[SLOTS];
    logic [10:0]                   list_head;
    logic [10:0]                   high_water;
    int                            full_replies = 0;
    // slots handed out and not yet freed by the stimulus, used while filling
    logic [gsa_pkg::INDEX_W-1:0]   live_slots[$];

    int error_count     = 0;
    int handles_checked = 0;
    int requests_queued = 0;
    int cycle_count     = 0;

    // sender and receiver pacing
    int send_gap    = 0;
    int send_steady = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    generational_slot_allocator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_slot           (i_slot),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_handle_index   (o_handle_index),
        .o_handle_version (o_handle_version)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // work out the handle that one accepted request returns and queue it
    task automatic predict_handle(input gsa_pkg::t_op op,
                                  input logic [gsa_pkg::SLOT_W-1:0] slot);
        t_handle h;
        h.status  = gsa_pkg::ST_OK;
        h.idx     = '0;
        h.version = '0;
        if (op == gsa_pkg::OP_ALLOC) begin
            if (list_head < SLOTS) begin
                // pop the free-list head
                h.idx     = list_head[gsa_pkg::INDEX_W-1:0];
                h.version = version_mem[list_head];
                list_head = link_mem[list_head];
            end else if (high_water < SLOTS) begin
                // list empty: take a fresh slot at version zero
                h.idx                   = high_water[gsa_pkg::INDEX_W-1:0];
                version_mem[high_water] = '0;
                high_water              = high_water + 1;
            end else begin
                h.status     = gsa_pkg::ST_FULL;
                full_replies = full_replies + 1;
            end
            if (h.status == gsa_pkg::ST_OK)
                live_slots.insert(live_slots.size(), h.idx);
        end else begin
            h.idx = slot;
            if ({1'b0, slot} >= high_water) begin
                // never handed out, nothing changes
                h.status = gsa_pkg::ST_INVALID;
            end else begin
                // push onto the list and bump the version, wrapping naturally
                link_mem[slot]    = list_head;
                version_mem[slot] = version_mem[slot] + 1'b1;
                h.version         = version_mem[slot];
                list_head         = {1'b0, slot};
            end
        end
        expected_handles.insert(expected_handles.size(), h);
    endtask

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (send_steady > 0) begin
            send_steady = send_steady - 1;
            return 0;
        end
        if (r < 3)
            send_steady = $urandom_range(20, 60);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // request driver: predicts on accept, then offers the next queued request
    always @(posedge i_clk) begin : request_driver
        t_request req;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                predict_handle(gsa_pkg::t_op'(i_operation), i_slot);
            if (i_in_valid && !o_in_ready) begin
                // keep offering the same request
            end else if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                req = request_queue.pop_front();
                i_in_valid  <= 1'b1;
                i_operation <= req.op;
                i_slot      <= req.slot;
                send_gap    <= pick_send_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result ready: random stalls plus one long hold once traffic is flowing,
    // long enough for the dut to back up and drop o_in_ready
    always @(posedge i_clk) begin : result_pacer
        int r;
        r = $urandom_range(0, 99);
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && handles_checked >= 400) begin
            hold_done   <= 1'b1;
            hold_left   <= 500;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (r < 70) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b0;
            if (r < 96)
                stall_left <= $urandom_range(0, 3);
            else
                stall_left <= $urandom_range(10, 50);
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_checker
        t_handle h;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            handles_checked <= handles_checked + 1;
            if (expected_handles.size() == 0) begin
                $error("result with nothing expected: status %0d index %0d version %0d",
                       o_status, o_handle_index, o_handle_version);
                error_count = error_count + 1;
            end else begin
                h = expected_handles.pop_front();
                if (o_status !== h.status) begin
                    $error("status: expected %0d, got %0d", h.status, o_status);
                    error_count = error_count + 1;
                end
                if (o_handle_index !== h.idx) begin
                    $error("handle_index: expected %0d, got %0d", h.idx, o_handle_index);
                    error_count = error_count + 1;
                end
                if (o_handle_version !== h.version) begin
                    $error("handle_version: expected %0d, got %0d",
                           h.version, o_handle_version);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // keep the pending queue shallow so the stimulus sees nearly current state
    task automatic queue_request(input gsa_pkg::t_op op,
                                 input logic [gsa_pkg::SLOT_W-1:0] slot);
        t_request req;
        while (request_queue.size() >= 1)
            @(posedge i_clk);
        req.op   = op;
        req.slot = slot;
        request_queue.insert(request_queue.size(), req);
        requests_queued = requests_queued + 1;
    endtask

    // every queued request has come back as a checked handle
    task automatic wait_idle();
        while (handles_checked < requests_queued)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        int                          r;
        int                          pick;
        int                          alloc_pct;
        logic [gsa_pkg::SLOT_W-1:0]  s;
        int                          waited;

        for (int k = 0; k < SLOTS; k++) begin
            link_mem[k]    = '0;
            version_mem[k] = '0;
        end
        list_head  = 11'(SLOTS);
        high_water = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: frees before anything was handed out
        queue_request(gsa_pkg::OP_FREE, 10'd0);
        queue_request(gsa_pkg::OP_FREE, 10'd1023);
        // fresh slots, slot field ignored on allocate
        queue_request(gsa_pkg::OP_ALLOC, 10'd1023);
        queue_request(gsa_pkg::OP_ALLOC, 10'd0);
        queue_request(gsa_pkg::OP_ALLOC, 10'd682);
        // two frees then pops in list order, versions bumped to one
        queue_request(gsa_pkg::OP_FREE, 10'd1);
        queue_request(gsa_pkg::OP_FREE, 10'd2);
        queue_request(gsa_pkg::OP_ALLOC, 10'd341);
        queue_request(gsa_pkg::OP_ALLOC, 10'd0);
        // list empty again: next fresh slot
        queue_request(gsa_pkg::OP_ALLOC, 10'd0);
        // free at and above the high-water mark, then free slot 0 and pop it back
        queue_request(gsa_pkg::OP_FREE, 10'd4);
        queue_request(gsa_pkg::OP_FREE, 10'd682);
        queue_request(gsa_pkg::OP_FREE, 10'd341);
        queue_request(gsa_pkg::OP_FREE, 10'd1023);
        queue_request(gsa_pkg::OP_FREE, 10'd0);
        queue_request(gsa_pkg::OP_ALLOC, 10'd1);

        // sender pauses until every handle is back
        wait_idle();

        // every slot below the mark is held here
        live_slots.delete();
        for (int k = 0; k < high_water; k++)
            live_slots.insert(live_slots.size(), k[gsa_pkg::INDEX_W-1:0]);

        // fill: allocation-heavy with frees of held slots only, so the list stays
        // acyclic and the allocator runs out; a few frees land above the mark
        while (full_replies < 8) begin
            r = $urandom_range(0, 99);
            if (r < 5 && high_water + 4 <= SLOTS - 1) begin
                s = 10'($urandom_range(high_water + 4, SLOTS - 1));
                queue_request(gsa_pkg::OP_FREE, s);
            end else if (r < 15 && live_slots.size() > 0) begin
                pick = $urandom_range(0, live_slots.size() - 1);
                s    = live_slots[pick];
                live_slots.delete(pick);
                queue_request(gsa_pkg::OP_FREE, s);
            end else begin
                queue_request(gsa_pkg::OP_ALLOC, 10'($urandom()));
            end
        end

        // random mix over the full slot range, double frees included
        alloc_pct = 50;
        for (int n = 0; n < 200; n++) begin
            if (n % 50 == 0)
                alloc_pct = ($urandom_range(0, 2) == 0) ? 20
                          : ($urandom_range(0, 1) == 0) ? 50 : 85;
            if ($urandom_range(0, 99) < alloc_pct)
                queue_request(gsa_pkg::OP_ALLOC, 10'($urandom()));
            else
                queue_request(gsa_pkg::OP_FREE, 10'($urandom()));
        end

        // drain, then give the pipeline time to show anything stray
        waited = 0;
        while (handles_checked < requests_queued && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited = waited + 1;
        end
        if (handles_checked < requests_queued) begin
            $error("%0d handles never returned", requests_queued - handles_checked);
            error_count = error_count + 1;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
sv/gsa_pkg.sv
sv/gsa_store.sv
sv/generational_slot_allocator.sv
bench/tb_generational_slot_allocator.sv
